FILE: design/cell_monitor_measure_sequencer_defines.svh
// Assertion macros shared by the measurement sequencer modules.
// No dependencies; define NO_ASSERTIONS to compile the checks out.
`ifndef CELL_MONITOR_MEASURE_SEQUENCER_DEFINES_SVH
`define CELL_MONITOR_MEASURE_SEQUENCER_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define CMMS_ASSERT_RST(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("cmms assertion failed");
`define CMMS_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("cmms assertion failed");
`else
`define CMMS_ASSERT_RST(label, clk, rst, prop)
`define CMMS_ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

FILE: design/cmms_pkg.sv
// Package for the cell monitor measurement sequencer: types, codes, limits
// and the ADC mode tables. No dependencies.
`timescale 1ns / 1ps

package cmms_pkg;

  localparam int NUM_DEVICES_DEF = 16;
  localparam int DEV_IDX_W       = 4;
  localparam int MAX_LATCHES     = 1 << DEV_IDX_W;

  // Supply windows in 100 uV codes: 2.99..3.01 V, 4.5..5.5 V, 2.7..3.6 V.
  localparam logic [15:0] REF_LO     = 16'd29900;
  localparam logic [15:0] REF_HI     = 16'd30100;
  localparam logic [15:0] ANALOG_LO  = 16'd45000;
  localparam logic [15:0] ANALOG_HI  = 16'd55000;
  localparam logic [15:0] DIGITAL_LO = 16'd27000;
  localparam logic [15:0] DIGITAL_HI = 16'd36000;

  localparam int CFG_ADDR_W = 4;
  localparam logic [1:0] REG_ADC_MODE   = 2'd0;
  localparam logic [1:0] REG_DISCHARGE  = 2'd1;
  localparam logic [1:0] REG_CELL_LIMIT = 2'd2;

  localparam logic REQ_TICK   = 1'b0;
  localparam logic REQ_HEALTH = 1'b1;

  typedef enum logic [2:0] {
    ST_INIT   = 3'd0,
    ST_MUX    = 3'd1,
    ST_CELL   = 3'd2,
    ST_AUX    = 3'd3,
    ST_STATUS = 3'd4
  } seq_state_t;

  typedef enum logic [2:0] {
    ACT_NONE         = 3'd0,
    ACT_MUX_DIAG     = 3'd1,
    ACT_START_CELL   = 3'd2,
    ACT_READ_CELL    = 3'd3,
    ACT_START_AUX    = 3'd4,
    ACT_READ_AUX     = 3'd5,
    ACT_START_STATUS = 3'd6
  } action_t;

  typedef struct packed {
    logic       ready_res;
    logic       discharge_bit;
    logic [1:0] adc_mode_code;
    action_t    action;
  } seq_res_t;

  typedef struct packed {
    logic [DEV_IDX_W-1:0] device_index;
    logic [15:0]          ref_code;
    logic [15:0]          analog_supply_code;
    logic [15:0]          digital_supply_code;
    logic [11:0]          ovuv_flags;
    logic [15:0]          max_cell_code;
    logic                 thermal_flag;
    logic                 mux_fail_flag;
  } health_in_t;

  typedef struct packed {
    logic ref_wrong;
    logic analog_wrong;
    logic digital_wrong;
    logic cell_limit_error;
    logic cell_range_error;
    logic thermal_trip;
    logic mux_fail;
  } health_res_t;

  function automatic logic [1:0] adc_mode_code_of(input logic [2:0] mode);
    logic [1:0] code;
    case (mode)
      3'd0, 3'd1: code = 2'd1;
      3'd2, 3'd3: code = 2'd2;
      3'd4, 3'd7: code = 2'd3;
      default:    code = 2'd0;
    endcase
    return code;
  endfunction

  // Conversion time in milliseconds for each speed mode.
  function automatic logic [7:0] adc_time_of(input logic [2:0] mode);
    logic [7:0] t;
    case (mode)
      3'd3, 3'd4: t = 8'd4;
      3'd5:       t = 8'd7;
      3'd6:       t = 8'd13;
      3'd7:       t = 8'd202;
      default:    t = 8'd2;
    endcase
    return t;
  endfunction

endpackage

FILE: design/cmms_seq.sv
// Measurement sequencer: steps through the conversion states on tick transfers.
// Depends on cmms_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "cell_monitor_measure_sequencer_defines.svh"

module cmms_seq
  import cmms_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        tick,
  input  logic [31:0] now_ms,
  input  logic [2:0]  adc_speed_mode,
  input  logic        discharge_en,
  output seq_res_t    res,
  output logic        ready_flag
);

  seq_state_t  state, state_next;
  logic        first_step, first_step_next;
  logic [31:0] state_start_ms, state_start_ms_next;
  logic        ready_flag_next;
  logic [31:0] elapsed;
  logic        done;
  action_t     act;
  logic        discharge;

  assign elapsed = now_ms - state_start_ms;
  assign done    = elapsed > {24'd0, adc_time_of(adc_speed_mode)};

  always_comb begin
    state_next          = state;
    state_start_ms_next = state_start_ms;
    first_step_next     = 1'b0;
    ready_flag_next     = ready_flag;
    act                 = ACT_NONE;
    discharge           = 1'b0;
    case (state)
      ST_MUX: begin
        act                 = ACT_MUX_DIAG;
        state_next          = ST_CELL;
        state_start_ms_next = now_ms;
        first_step_next     = 1'b1;
      end
      ST_CELL: begin
        if (first_step) begin
          act       = ACT_START_CELL;
          discharge = discharge_en;
        end else if (done) begin
          act                 = ACT_READ_CELL;
          state_next          = ST_AUX;
          state_start_ms_next = now_ms;
          first_step_next     = 1'b1;
        end
      end
      ST_AUX: begin
        if (first_step) begin
          act = ACT_START_AUX;
        end else if (done) begin
          act                 = ACT_READ_AUX;
          state_next          = ST_STATUS;
          state_start_ms_next = now_ms;
          first_step_next     = 1'b1;
        end
      end
      ST_STATUS: begin
        if (first_step) begin
          act = ACT_START_STATUS;
        end else if (done) begin
          ready_flag_next     = 1'b1;
          state_next          = ST_CELL;
          state_start_ms_next = now_ms;
          first_step_next     = 1'b1;
        end
      end
      default: begin
        state_next          = ST_MUX;
        state_start_ms_next = now_ms;
        first_step_next     = 1'b1;
      end
    endcase

    res.action        = act;
    res.adc_mode_code = (act == ACT_START_CELL || act == ACT_START_AUX ||
                         act == ACT_START_STATUS) ? adc_mode_code_of(adc_speed_mode) : 2'd0;
    res.discharge_bit = discharge;
    res.ready_res     = ready_flag_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_INIT;
      first_step     <= 1'b1;
      state_start_ms <= 32'd0;
      ready_flag     <= 1'b0;
    end else if (tick) begin
      state          <= state_next;
      first_step     <= first_step_next;
      state_start_ms <= state_start_ms_next;
      ready_flag     <= ready_flag_next;
    end
  end

  `CMMS_ASSERT_RST(a_ready_sticky, clk, rst, !$fell(ready_flag))
  `CMMS_ASSERT_RST(a_ready_from_status, clk, rst, $rose(ready_flag) |-> $past(state) == ST_STATUS)
  `CMMS_ASSERT_RST(a_enter_sets_first, clk, rst, (tick && state_next != state) |=> first_step)
  `CMMS_ASSERT_RST(a_start_on_first, clk, rst, (tick && (res.action == ACT_START_CELL || res.action == ACT_START_AUX || res.action == ACT_START_STATUS)) |-> first_step)

endmodule

FILE: design/cmms_health.sv
// Device health checks: supply windows, cell flags and the thermal latches.
// Depends on cmms_pkg.
`timescale 1ns / 1ps

module cmms_health
  import cmms_pkg::*;
#(
  parameter int NUM_DEVICES = NUM_DEVICES_DEF
)
(
  input  logic        clk,
  input  logic        rst,
  input  logic        report,
  input  health_in_t  hin,
  input  logic        ready_flag,
  input  logic [15:0] cell_code_limit,
  output health_res_t res
);

  localparam int LATCH_DEPTH = (NUM_DEVICES < MAX_LATCHES) ? NUM_DEVICES : MAX_LATCHES;
  localparam int LATCH_AW    = (LATCH_DEPTH > 1) ? $clog2(LATCH_DEPTH) : 1;

  logic [LATCH_DEPTH-1:0] thermal_latch;
  logic [LATCH_AW-1:0]    idx;
  logic                   in_range;
  logic                   latch_new;

  assign in_range  = 32'(hin.device_index) < NUM_DEVICES;
  assign idx       = LATCH_AW'(hin.device_index);
  assign latch_new = in_range ? ((ready_flag & thermal_latch[idx]) | hin.thermal_flag)
                              : hin.thermal_flag;

  always_ff @(posedge clk) begin
    if (rst) begin
      thermal_latch <= '0;
    end else if (report && in_range) begin
      thermal_latch[idx] <= latch_new;
    end
  end

  always_comb begin
    res.ref_wrong        = hin.ref_code < REF_LO || hin.ref_code > REF_HI;
    res.analog_wrong     = hin.analog_supply_code < ANALOG_LO ||
                           hin.analog_supply_code > ANALOG_HI;
    res.digital_wrong    = hin.digital_supply_code < DIGITAL_LO ||
                           hin.digital_supply_code > DIGITAL_HI;
    res.cell_limit_error = |hin.ovuv_flags;
    res.cell_range_error = hin.max_cell_code > cell_code_limit;
    res.thermal_trip     = latch_new;
    res.mux_fail         = hin.mux_fail_flag;
  end

endmodule

FILE: design/cell_monitor_measure_sequencer.sv
// A result is registered on m_tdata in the cycle after its input transfer.
// Throughput: one item per cycle; the output register takes a new result in the
// same cycle that the previous one is taken, so only a stalled output stops input.
// Reset (rst, synchronous) returns the sequencer to init, clears ready, the
// thermal latches and the output, and loads the register defaults.
// Top level; depends on cmms_pkg, cmms_seq, cmms_health and the macro header.
`timescale 1ns / 1ps
`include "cell_monitor_measure_sequencer_defines.svh"

module cell_monitor_measure_sequencer
  import cmms_pkg::*;
#(
  parameter int NUM_DEVICES = NUM_DEVICES_DEF
)
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // now_ms[31:0], device_index[35:32], ref_code[51:36], analog_supply_code[67:52],
  // digital_supply_code[83:68], ovuv_flags[95:84], max_cell_code[111:96],
  // thermal_flag[112], mux_fail_flag[113], zero[119:114]
  input  logic [119:0]          s_tdata,
  // req_type[0]
  input  logic                  s_tuser,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // action[2:0], adc_mode_code[4:3], discharge_bit[5], ready_res[6], ref_wrong[7],
  // analog_wrong[8], digital_wrong[9], cell_limit_error[10], cell_range_error[11],
  // thermal_trip[12], mux_fail[13], zero[15:14]
  output logic [15:0]           m_tdata,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  logic [2:0]  adc_speed_mode;
  logic        discharge_during_conversion;
  logic [15:0] cell_code_limit;
  logic        cfg_wr;
  logic [1:0]  cfg_idx;

  logic        accept, tick, report;
  logic [31:0] now_ms;
  health_in_t  hin;
  seq_res_t    seq_res;
  health_res_t hl_res;
  logic        ready_flag;
  logic [15:0] data_next;
  seq_res_t    out_seq;

  assign pready  = 1'b1;
  assign cfg_idx = paddr[3:2];
  assign cfg_wr  = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      adc_speed_mode              <= 3'd2;
      discharge_during_conversion <= 1'b0;
      cell_code_limit             <= 16'hFFFF;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_ADC_MODE:   adc_speed_mode              <= pwdata[2:0];
        REG_DISCHARGE:  discharge_during_conversion <= pwdata[0];
        REG_CELL_LIMIT: cell_code_limit             <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_ADC_MODE:   prdata = {29'd0, adc_speed_mode};
      REG_DISCHARGE:  prdata = {31'd0, discharge_during_conversion};
      REG_CELL_LIMIT: prdata = {16'd0, cell_code_limit};
      default:        prdata = 32'd0;
    endcase
  end

  assign s_tready = ~m_tvalid | m_tready;
  assign accept   = s_tvalid & s_tready;
  assign tick     = accept & (s_tuser == REQ_TICK);
  assign report   = accept & (s_tuser == REQ_HEALTH);

  assign now_ms                  = s_tdata[31:0];
  assign hin.device_index        = s_tdata[35:32];
  assign hin.ref_code            = s_tdata[51:36];
  assign hin.analog_supply_code  = s_tdata[67:52];
  assign hin.digital_supply_code = s_tdata[83:68];
  assign hin.ovuv_flags          = s_tdata[95:84];
  assign hin.max_cell_code       = s_tdata[111:96];
  assign hin.thermal_flag        = s_tdata[112];
  assign hin.mux_fail_flag       = s_tdata[113];

  cmms_seq u_seq (
    .clk            (clk),
    .rst            (rst),
    .tick           (tick),
    .now_ms         (now_ms),
    .adc_speed_mode (adc_speed_mode),
    .discharge_en   (discharge_during_conversion),
    .res            (seq_res),
    .ready_flag     (ready_flag)
  );

  cmms_health #(
    .NUM_DEVICES (NUM_DEVICES)
  ) u_health (
    .clk             (clk),
    .rst             (rst),
    .report          (report),
    .hin             (hin),
    .ready_flag      (ready_flag),
    .cell_code_limit (cell_code_limit),
    .res             (hl_res)
  );

  always_comb begin
    if (s_tuser == REQ_TICK) begin
      data_next = {9'd0, seq_res};
    end else begin
      data_next = {2'd0, hl_res.mux_fail, hl_res.thermal_trip,
                   hl_res.cell_range_error, hl_res.cell_limit_error,
                   hl_res.digital_wrong, hl_res.analog_wrong, hl_res.ref_wrong,
                   ready_flag, 6'd0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      m_tdata  <= 16'd0;
    end else begin
      if (accept) begin
        m_tvalid <= 1'b1;
        m_tdata  <= data_next;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  assign out_seq = seq_res_t'(m_tdata[6:0]);

  `CMMS_ASSERT_RST(a_accept_gives_result, clk, rst, accept |=> m_tvalid)
  `CMMS_ASSERT_RST(a_mode_only_on_start, clk, rst, (m_tvalid && out_seq.adc_mode_code != 2'd0) |-> (out_seq.action == ACT_START_CELL || out_seq.action == ACT_START_AUX || out_seq.action == ACT_START_STATUS))
  `CMMS_ASSERT_RST(a_cfg_mode_write, clk, rst, (cfg_wr && cfg_idx == REG_ADC_MODE) |=> adc_speed_mode == $past(pwdata[2:0]))

endmodule

FILE: tb/sv/tb.sv
// Self-checking testbench for cell_monitor_measure_sequencer: directed rows, then random
// tick and health transfers under several register settings, checked by an in-bench model.
// Depends on cmms_pkg and the RTL of the block.
`timescale 1ns / 1ps

module tb;
  import cmms_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam int PHASES = 10;
  localparam int ITEMS_PER_PHASE = 175;
  localparam logic [1:0] REG_SPARE = 2'd3;
  // Mode code and conversion time per speed mode, mode 0 in the lowest slice.
  localparam logic [15:0] MODE_CODES = 16'b11_00_00_11_10_10_01_01;
  localparam logic [63:0] CONV_MS = {8'd202, 8'd13, 8'd7, 8'd4, 8'd4, 8'd2, 8'd2, 8'd2};

  typedef struct packed {
    logic         kind;
    logic [119:0] data;
    logic         typed;
    logic [15:0]  word;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [119:0] s_tdata = '0;
  logic s_tuser = 1'b0;
  logic m_tvalid;
  logic m_tready = 1'b1;
  logic [15:0] m_tdata;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  cell_monitor_measure_sequencer uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready)
  );

  always #6 clk = ~clk;

  // Model state and register copies.
  seq_state_t  cur_state = ST_INIT;
  logic        first_tick = 1'b1;
  logic [31:0] conv_start_ms = '0;
  logic        pass_done = 1'b0;
  logic [15:0] thermal_hold = '0;
  logic [2:0]  speed_mode = 3'd2;
  logic        discharge_en = 1'b0;
  logic [15:0] cell_limit = 16'hFFFF;

  logic [15:0] pending_results[$];
  stim_row_t   directed_rows[$];
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;
  int unsigned stall_left = 0;
  logic        quiet = 1'b0;
  logic        sender_gaps = 1'b1;
  logic [31:0] clock_ms = '0;

  function automatic void move_to(input seq_state_t next, input logic [31:0] now);
    cur_state = next;
    conv_start_ms = now;
    first_tick = 1'b1;
  endfunction

  function automatic logic [15:0] next_result_word(input logic kind, input logic [119:0] d);
    logic [15:0] w;
    logic [31:0] now;
    logic [31:0] elapsed;
    logic was_first;
    logic done;
    action_t act;
    logic [3:0] dev;
    logic th;
    w = '0;
    if (kind == REQ_TICK) begin
      now = d[31:0];
      was_first = first_tick;
      elapsed = now - conv_start_ms;
      done = elapsed > {24'd0, CONV_MS[8*speed_mode +: 8]};
      act = ACT_NONE;
      first_tick = 1'b0;
      case (cur_state)
        ST_MUX: begin
          act = ACT_MUX_DIAG;
          move_to(ST_CELL, now);
        end
        ST_CELL: begin
          if (was_first) begin
            act = ACT_START_CELL;
            w[5] = discharge_en;
          end else if (done) begin
            act = ACT_READ_CELL;
            move_to(ST_AUX, now);
          end
        end
        ST_AUX: begin
          if (was_first) begin
            act = ACT_START_AUX;
          end else if (done) begin
            act = ACT_READ_AUX;
            move_to(ST_STATUS, now);
          end
        end
        ST_STATUS: begin
          if (was_first) begin
            act = ACT_START_STATUS;
          end else if (done) begin
            pass_done = 1'b1;
            move_to(ST_CELL, now);
          end
        end
        default: begin
          move_to(ST_MUX, now);
        end
      endcase
      w[2:0] = act;
      if (act == ACT_START_CELL || act == ACT_START_AUX || act == ACT_START_STATUS) begin
        w[4:3] = MODE_CODES[2*speed_mode +: 2];
      end
      w[6] = pass_done;
    end else begin
      dev = d[35:32];
      th = d[112];
      if (int'(dev) < NUM_DEVICES_DEF) begin
        thermal_hold[dev] = pass_done ? (thermal_hold[dev] | th) : th;
        th = thermal_hold[dev];
      end
      w[6] = pass_done;
      w[7] = d[51:36] < REF_LO || d[51:36] > REF_HI;
      w[8] = d[67:52] < ANALOG_LO || d[67:52] > ANALOG_HI;
      w[9] = d[83:68] < DIGITAL_LO || d[83:68] > DIGITAL_HI;
      w[10] = |d[95:84];
      w[11] = d[111:96] > cell_limit;
      w[12] = th;
      w[13] = d[113];
    end
    return w;
  endfunction

  function automatic logic [119:0] tick_data(input logic [31:0] now);
    return {88'd0, now};
  endfunction

  function automatic logic [119:0] health_data(input logic [3:0] dev, input logic [15:0] refc,
      input logic [15:0] ana, input logic [15:0] dig, input logic [11:0] ovuv,
      input logic [15:0] maxc, input logic th, input logic mux);
    return {6'd0, mux, th, maxc, ovuv, dig, ana, refc, dev, 32'd0};
  endfunction

  function automatic logic [15:0] pick_code(input logic [15:0] lo, input logic [15:0] hi);
    logic [15:0] c;
    case ($urandom_range(0, 6))
      0: c = lo - 16'd1;
      1: c = lo;
      2: c = hi;
      3: c = hi + 16'd1;
      4, 5: c = 16'($urandom_range(lo, hi));
      default: c = 16'($urandom);
    endcase
    return c;
  endfunction

  task automatic add_row(input logic kind, input logic [119:0] data, input logic typed,
      input logic [15:0] word);
    directed_rows.push_back('{kind: kind, data: data, typed: typed, word: word});
  endtask

  task automatic send_item(input logic kind, input logic [119:0] data, input logic typed,
      input logic [15:0] word);
    logic [15:0] predicted;
    if (sender_gaps && !quiet && $urandom_range(0, 5) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= kind;
    s_tdata <= data;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predicted = next_result_word(kind, data);
    pending_results.push_back(typed ? word : predicted);
    @(negedge clk);
  endtask

  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (idx == REG_ADC_MODE) speed_mode = value[2:0];
    else if (idx == REG_DISCHARGE) discharge_en = value[0];
    else if (idx == REG_CELL_LIMIT) cell_limit = value[15:0];
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk);
  endtask

  task automatic send_random_item();
    logic [31:0] step;
    logic [119:0] d;
    logic [11:0] ovuv;
    logic [15:0] maxc;
    if ($urandom_range(0, 9) < 6) begin
      step = {24'd0, CONV_MS[8*speed_mode +: 8]};
      case ($urandom_range(0, 24))
        0: clock_ms = $urandom;
        1: clock_ms = clock_ms;
        default: clock_ms = clock_ms + $urandom_range(0, step + step / 2 + 2);
      endcase
      d = tick_data(clock_ms);
      if ($urandom_range(0, 7) == 0) begin
        d[113:32] = {$urandom, $urandom, $urandom};
      end
      send_item(REQ_TICK, d, 1'b0, '0);
    end else begin
      case ($urandom_range(0, 3))
        0, 1: ovuv = '0;
        2: ovuv = 12'd1 << $urandom_range(0, 11);
        default: ovuv = 12'($urandom);
      endcase
      case ($urandom_range(0, 4))
        0: maxc = cell_limit - 16'd1;
        1: maxc = cell_limit;
        2: maxc = cell_limit + 16'd1;
        default: maxc = 16'($urandom);
      endcase
      d = health_data(4'($urandom), pick_code(REF_LO, REF_HI),
        pick_code(ANALOG_LO, ANALOG_HI), pick_code(DIGITAL_LO, DIGITAL_HI), ovuv, maxc,
        $urandom_range(0, 5) == 0, 1'($urandom));
      d[31:0] = $urandom;
      send_item(REQ_HEALTH, d, 1'b0, '0);
    end
  endtask

  function automatic void check_field(input string name, input logic [15:0] want,
      input logic [15:0] got);
    if (want !== got) begin
      mismatch_count++;
      if (mismatch_count <= 60) begin
        $display("%0t ns: field %s expected %0h, got %0h", $time, name, want, got);
      end
    end
  endfunction

  always @(negedge clk) begin
    if (rst || quiet) begin
      m_tready <= 1'b1;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      m_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 15) == 0) begin
      m_tready <= 1'b0;
      stall_left <= $urandom_range(0, 13);
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    logic [15:0] want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        $display("%0t ns: unexpected result, expected none, got %0h", $time, m_tdata);
      end else begin
        want = pending_results.pop_front();
        check_field("action", 16'(want[2:0]), 16'(m_tdata[2:0]));
        check_field("adc_mode_code", 16'(want[4:3]), 16'(m_tdata[4:3]));
        check_field("discharge_bit", 16'(want[5]), 16'(m_tdata[5]));
        check_field("ready_res", 16'(want[6]), 16'(m_tdata[6]));
        check_field("ref_wrong", 16'(want[7]), 16'(m_tdata[7]));
        check_field("analog_wrong", 16'(want[8]), 16'(m_tdata[8]));
        check_field("digital_wrong", 16'(want[9]), 16'(m_tdata[9]));
        check_field("cell_limit_error", 16'(want[10]), 16'(m_tdata[10]));
        check_field("cell_range_error", 16'(want[11]), 16'(m_tdata[11]));
        check_field("thermal_trip", 16'(want[12]), 16'(m_tdata[12]));
        check_field("mux_fail", 16'(want[13]), 16'(m_tdata[13]));
        check_field("padding", 16'(want[15:14]), 16'(m_tdata[15:14]));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    add_row(REQ_TICK, tick_data(32'd0), 1'b1, 16'h0000);
    // Before ready, the thermal latch is loaded, so a clear bit overwrites a set one.
    add_row(REQ_HEALTH, health_data(4'd5, 0, 0, 0, 0, 0, 1, 0), 1'b1, 16'h1380);
    add_row(REQ_HEALTH, health_data(4'd5, 0, 0, 0, 0, 0, 0, 0), 1'b1, 16'h0380);
    add_row(REQ_HEALTH, health_data(4'd9, 0, 0, 0, 0, 0, 1, 0), 1'b1, 16'h1380);
    add_row(REQ_TICK, tick_data(32'd1), 1'b1, 16'h0001);
    add_row(REQ_TICK, tick_data(32'd1), 1'b1, 16'h0012);
    add_row(REQ_TICK, tick_data(32'd3), 1'b0, 16'h0000);
    add_row(REQ_TICK, tick_data(32'd4), 1'b1, 16'h0003);
    add_row(REQ_TICK, tick_data(32'd4), 1'b1, 16'h0014);
    add_row(REQ_TICK, tick_data(32'd7), 1'b1, 16'h0005);
    add_row(REQ_TICK, tick_data(32'd7), 1'b1, 16'h0016);
    add_row(REQ_TICK, tick_data(32'd10), 1'b1, 16'h0040);
    add_row(REQ_HEALTH, health_data(4'd5, 0, 0, 0, 0, 0, 0, 0), 1'b1, 16'h03C0);
    add_row(REQ_HEALTH, health_data(4'd9, 0, 0, 0, 0, 0, 0, 0), 1'b1, 16'h13C0);
    add_row(REQ_HEALTH, health_data(4'd15, 16'd29900, 16'd45000, 16'd27000, 12'hFFF,
      16'hFFFF, 1, 1), 1'b1, 16'h3440);
    add_row(REQ_HEALTH, health_data(4'd15, 16'd30100, 16'd55000, 16'd36000, 12'h800,
      16'h0000, 0, 0), 1'b1, 16'h1440);
    add_row(REQ_HEALTH, health_data(4'd3, 16'd29899, 16'd44999, 16'd26999, 12'h001,
      16'h0000, 0, 0), 1'b1, 16'h07C0);
    add_row(REQ_HEALTH, health_data(4'd7, 16'd30101, 16'd55001, 16'd36001, 12'h000,
      16'hFFFF, 1, 0), 1'b1, 16'h13C0);
    add_row(REQ_HEALTH, health_data(4'd15, 16'hFFFF, 16'hFFFF, 16'hFFFF, 12'hFFF,
      16'hFFFF, 1, 1), 1'b1, 16'h37C0);
    // The elapsed time is taken modulo 2^32 across the wrap of the millisecond counter.
    add_row(REQ_TICK, tick_data(32'hFFFF_FFFF), 1'b1, 16'h0052);
    add_row(REQ_TICK, tick_data(32'hFFFF_FFFE), 1'b1, 16'h0043);
    add_row(REQ_TICK, tick_data(32'hFFFF_FFFE), 1'b1, 16'h0054);
    add_row(REQ_TICK, tick_data(32'd1), 1'b1, 16'h0045);
    add_row(REQ_TICK, tick_data(32'd1), 1'b1, 16'h0056);
    add_row(REQ_TICK, tick_data(32'd2), 1'b0, 16'h0000);

    repeat (7) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    foreach (directed_rows[i]) begin
      send_item(directed_rows[i].kind, directed_rows[i].data, directed_rows[i].typed,
        directed_rows[i].word);
    end
    clock_ms = 32'd2;

    for (int p = 0; p < PHASES; p++) begin
      wait_idle();
      write_reg(REG_ADC_MODE, 32'((p * 5) % 8));
      write_reg(REG_DISCHARGE, 32'(p % 2 == 0));
      if (p == 0) write_reg(REG_CELL_LIMIT, 32'd0);
      else if (p == 1) write_reg(REG_CELL_LIMIT, 32'hFFFF);
      else write_reg(REG_CELL_LIMIT, $urandom);
      if (p == 2) write_reg(REG_SPARE, $urandom);
      quiet = (p == PHASES - 1);
      sender_gaps = ($urandom_range(0, 3) != 0);
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        send_random_item();
      end
    end

    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
